// ===== rtl/bounded_list_store_assert.svh =====
// Assertion shorthands used by the list store sequencer (bls_seq).
`ifndef BOUNDED_LIST_STORE_ASSERT_SVH
`define BOUNDED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_list_store: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_list_store: next-cycle check failed");

`endif

// ===== rtl/bls_pkg.sv =====
`default_nettype none

package bls_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = 10;
    localparam int CNTO_W = 11;
    localparam int WORD_W = 64;
    localparam int CMP_W  = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_SWAP   = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]        func;
        logic [IDX_W-1:0]  index_a;
        logic [IDX_W-1:0]  index_b;
        logic [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [1:0]        status;
        logic [CNTO_W-1:0] count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SWA,
        S_SWB,
        S_SWC,
        S_RM,
        S_RESP
    } t_state;

    function automatic logic idx_live(input logic [IDX_W-1:0] idx,
                                      input logic [CNT_W-1:0] cnt);
        return CMP_W'(idx) < CMP_W'(cnt);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bounded_list_store.sv =====
// Channel   Direction  Valid         Stall         Payload
// request   in         i_req_valid   o_req_stall   i_req  (func, index_a, index_b, value)
// response  out        o_rsp_valid   i_rsp_stall   o_rsp  (read_value, status, count)
//
// One request is worked at a time against a single 1024 x 64 RAM (one write and one
// read port, registered read). Read passes S_READ, swap S_SWA to S_SWC and remove
// S_RM (one word moved per cycle through the RAM ports; none for the last word); all
// else goes to S_RESP. Reset clears the count and control only; the RAM needs no
// clearing. A stalled response sits in the output register while the next request
// is already worked; that request waits only when it is ready to respond.
`default_nettype none

module bounded_list_store
    import bls_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);

    logic              push;
    logic              out_ready;
    t_rsp              seq_rsp;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    bls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bls_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_push      (push),
        .o_rsp       (seq_rsp),
        .i_out_ready (out_ready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    bls_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rsp   (seq_rsp),
        .o_ready (out_ready),
        .o_valid (o_rsp_valid),
        .i_stall (i_rsp_stall),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/bls_ram.sv =====
`default_nettype none

module bls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bls_out.sv =====
`default_nettype none

module bls_out
    import bls_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rsp i_rsp,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);

    logic r_valid;
    logic n_valid;
    t_rsp r_rsp;

    // Slot is free when empty or when its beat leaves this cycle.
    assign o_ready = !r_valid || !i_stall;
    assign n_valid = i_push || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ===== rtl/bls_seq.sv =====
`default_nettype none

`include "bounded_list_store_assert.svh"

module bls_seq
    import bls_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_stall,
    input  wire t_req               i_req,
    output logic                    o_push,
    output t_rsp                    o_rsp,
    input  wire logic               i_out_ready,
    output logic                    o_mem_we,
    output logic [ADDR_W-1:0]       o_mem_waddr,
    output logic [WORD_W-1:0]       o_mem_wdata,
    output logic                    o_mem_re,
    output logic [ADDR_W-1:0]       o_mem_raddr,
    input  wire logic [WORD_W-1:0]  i_mem_rdata
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_k, n_k;
    logic [ADDR_W-1:0]  r_ib, n_ib;
    logic [WORD_W-1:0]  r_tmp, n_tmp;
    t_rsp               r_rsp, n_rsp;

    logic               accept;
    logic               ok_a;
    logic               ok_b;
    logic               full;
    logic               rm_walk;
    logic               rm_more;
    logic [CMP_W-1:0]   ia_next;

    assign accept  = i_req_valid && (r_state == S_IDLE);
    assign ok_a    = idx_live(i_req.index_a, r_count);
    assign ok_b    = idx_live(i_req.index_b, r_count);
    assign full    = CMP_W'(r_count) >= CMP_W'(DEPTH);
    assign ia_next = CMP_W'(i_req.index_a) + CMP_W'(1);
    assign rm_walk = ia_next < CMP_W'(r_count);
    // r_count already holds the reduced count while walking.
    assign rm_more = (CMP_W'(r_k) + CMP_W'(1)) < CMP_W'(r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_RESP;
                    case (i_req.func)
                        OP_READ:   if (ok_a) n_state = S_READ;
                        OP_SWAP:   if (ok_a && ok_b) n_state = S_SWA;
                        OP_REMOVE: if (ok_a && rm_walk) n_state = S_RM;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_READ:  n_state = S_RESP;
            S_SWA:   n_state = S_SWB;
            S_SWB:   n_state = S_SWC;
            S_SWC:   n_state = S_RESP;
            S_RM:    if (!rm_more) n_state = S_RESP;
            S_RESP:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_k;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = ADDR_W'(i_req.index_a);
        o_push      = 1'b0;
        o_req_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.func)
                        OP_APPEND: begin
                            o_mem_we    = !full;
                            o_mem_waddr = ADDR_W'(r_count);
                            o_mem_wdata = i_req.value;
                        end
                        OP_READ: o_mem_re = ok_a;
                        OP_WRITE: begin
                            o_mem_we    = ok_a;
                            o_mem_waddr = ADDR_W'(i_req.index_a);
                            o_mem_wdata = i_req.value;
                        end
                        OP_SWAP: o_mem_re = ok_a && ok_b;
                        OP_REMOVE: begin
                            o_mem_re    = ok_a && rm_walk;
                            o_mem_raddr = ADDR_W'(ia_next);
                        end
                        default: o_mem_re = 1'b0;
                    endcase
                end
            end
            S_SWA: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_ib;
            end
            S_SWB: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_k;
                o_mem_wdata = i_mem_rdata;
            end
            S_SWC: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ib;
                o_mem_wdata = r_tmp;
            end
            S_RM: begin
                // Move word k+1 down to k, fetch k+2 for the next beat.
                o_mem_we    = 1'b1;
                o_mem_waddr = r_k;
                o_mem_wdata = i_mem_rdata;
                o_mem_re    = rm_more;
                o_mem_raddr = ADDR_W'(CMP_W'(r_k) + CMP_W'(2));
            end
            S_RESP:  o_push = i_out_ready;
            default: o_push = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_k     = r_k;
        n_ib    = r_ib;
        n_tmp   = r_tmp;
        n_rsp   = r_rsp;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_k              = ADDR_W'(i_req.index_a);
                    n_ib             = ADDR_W'(i_req.index_b);
                    n_rsp.read_value = '0;
                    n_rsp.status     = ST_DONE;
                    case (i_req.func)
                        OP_APPEND: begin
                            if (full) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_READ, OP_WRITE: begin
                            if (!ok_a) n_rsp.status = ST_BAD_INDEX;
                        end
                        OP_SWAP: begin
                            if (!(ok_a && ok_b)) n_rsp.status = ST_BAD_INDEX;
                        end
                        OP_REMOVE: begin
                            if (ok_a) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                n_rsp.status = ST_BAD_INDEX;
                            end
                        end
                        default: n_rsp.status = ST_DONE;
                    endcase
                    n_rsp.count = CNTO_W'(n_count);
                end
            end
            S_READ: n_rsp.read_value = i_mem_rdata;
            S_SWA:  n_tmp = i_mem_rdata;
            S_RM:   n_k = r_k + ADDR_W'(1);
            default: n_tmp = r_tmp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_ib  <= n_ib;
        r_tmp <= n_tmp;
        r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

    `BLS_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, CMP_W'(r_count) <= CMP_W'(DEPTH))
    `BLS_ASSERT_NOW(a_idle_no_write, i_clk, i_rst_n, (r_state == S_IDLE) && !accept, !o_mem_we)
    `BLS_ASSERT_NOW(a_walk_in_range, i_clk, i_rst_n, r_state == S_RM, CMP_W'(r_k) < CMP_W'(r_count))
    `BLS_ASSERT_NEXT(a_push_to_idle, i_clk, i_rst_n, o_push, r_state == S_IDLE)
    `BLS_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, o_push, i_out_ready)

endmodule

`default_nettype wire

// ===== verif/tb_bounded_list_store.sv =====
module tb_bounded_list_store;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int TOTAL_TARGET = 1700;

    // Codes outside the operation set: the block must leave the list alone.
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    typedef struct {
        t_req req;
        bit   drain;
    } t_planned_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_stall;
    t_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;

    t_planned_req req_plan_q[$];
    t_rsp         expected_rsp_q[$];

    logic [WORD_W-1:0] shadow_words [DEPTH];
    int unsigned       shadow_len = 0;
    int unsigned       plan_len = 0;

    int   items_sent = 0;
    int   rsp_seen = 0;
    int   mismatches = 0;
    int   total_items;
    int   cycle_cnt = 0;
    int   idle_left = 0;
    int   stall_left = 0;
    bit   drv_burst = 1'b0;
    bit   rsp_burst = 1'b0;
    t_rsp want_rsp;
    t_planned_req next_beat;

    bounded_list_store DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    // List behavior: apply one request to the shadow list, return its response.
    function automatic t_rsp list_apply(t_req r);
        t_rsp              res;
        int unsigned       a;
        int unsigned       b;
        int unsigned       k;
        logic [WORD_W-1:0] held;
        a = r.index_a;
        b = r.index_b;
        res = '0;
        res.status = ST_DONE;
        case (r.func)
            OP_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[shadow_len] = r.value;
                    shadow_len++;
                end
            end
            OP_READ: begin
                if (a < shadow_len) res.read_value = shadow_words[a];
                else res.status = ST_BAD_INDEX;
            end
            OP_WRITE: begin
                if (a < shadow_len) shadow_words[a] = r.value;
                else res.status = ST_BAD_INDEX;
            end
            OP_SWAP: begin
                if (a < shadow_len && b < shadow_len) begin
                    held = shadow_words[a];
                    shadow_words[a] = shadow_words[b];
                    shadow_words[b] = held;
                end else begin
                    res.status = ST_BAD_INDEX;
                end
            end
            OP_REMOVE: begin
                if (a < shadow_len) begin
                    for (k = a; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k + 1];
                    shadow_len--;
                end else begin
                    res.status = ST_BAD_INDEX;
                end
            end
            default: ;
        endcase
        res.count = CNTO_W'(shadow_len);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at response %0d: %s got %0h expected %0h",
                 rsp_seen, what, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // Track the list length as the plan grows, so indices can be aimed.
    function automatic void plan(logic [2:0] f, int unsigned a, int unsigned b,
                                 logic [WORD_W-1:0] v, bit drain = 1'b0);
        t_planned_req e;
        e.req.func = f;
        e.req.index_a = a[IDX_W-1:0];
        e.req.index_b = b[IDX_W-1:0];
        e.req.value = v;
        e.drain = drain;
        req_plan_q.push_back(e);
        if (f == OP_APPEND && plan_len < DEPTH) plan_len++;
        else if (f == OP_REMOVE && a < plan_len) plan_len--;
    endfunction

    function automatic int unsigned pick_pos(int unsigned bad_pct);
        int unsigned r;
        if (plan_len == 0 || (plan_len < DEPTH && $urandom_range(1, 100) <= bad_pct)) begin
            r = $urandom_range(0, 2);
            if (r == 0) return plan_len;
            if (r == 1) return DEPTH - 1;
            return $urandom_range(plan_len, DEPTH - 1);
        end
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return plan_len - 1;
        return $urandom_range(0, plan_len - 1);
    endfunction

    function automatic void plan_random(int w_app, int w_rm, bit drain);
        int r;
        int s;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        if (r < w_app) begin
            plan(OP_APPEND, $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1),
                 rand_word(), drain);
        end else if (r < w_app + w_rm) begin
            plan(OP_REMOVE, pick_pos(10), $urandom_range(0, DEPTH - 1), rand_word(), drain);
        end else if (s < 30) begin
            plan(OP_READ, pick_pos(12), $urandom_range(0, DEPTH - 1), rand_word(), drain);
        end else if (s < 55) begin
            plan(OP_WRITE, pick_pos(12), $urandom_range(0, DEPTH - 1), rand_word(), drain);
        end else if (s < 95) begin
            plan(OP_SWAP, pick_pos(8), pick_pos(8), rand_word(), drain);
        end else begin
            case ($urandom_range(0, 2))
                0: plan(OP_SPARE_A, pick_pos(50), pick_pos(50), rand_word(), drain);
                1: plan(OP_SPARE_B, pick_pos(50), pick_pos(50), rand_word(), drain);
                default: plan(OP_SPARE_C, pick_pos(50), pick_pos(50), rand_word(), drain);
            endcase
        end
    endfunction

    // Request driver: hold a stalled beat, otherwise advance through the plan.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!(i_req_valid && o_req_stall)) begin
            if (i_req_valid) begin
                expected_rsp_q.push_back(list_apply(i_req));
                items_sent++;
            end
            if (idle_left > 0) begin
                idle_left--;
                i_req_valid <= 1'b0;
            end else if (req_plan_q.size() != 0
                         && !(req_plan_q[0].drain && rsp_seen != items_sent)) begin
                next_beat = req_plan_q.pop_front();
                i_req_valid <= 1'b1;
                i_req <= next_beat.req;
                if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
                idle_left = pick_gap(drv_burst);
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // Response monitor: check each beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                rsp_seen <= rsp_seen + 1;
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("response with nothing outstanding", o_rsp.read_value, 0);
                end else begin
                    want_rsp = expected_rsp_q.pop_front();
                    if (o_rsp.read_value !== want_rsp.read_value)
                        report_mismatch("read_value", o_rsp.read_value, want_rsp.read_value);
                    if (o_rsp.status !== want_rsp.status)
                        report_mismatch("status", o_rsp.status, want_rsp.status);
                    if (o_rsp.count !== want_rsp.count)
                        report_mismatch("count", o_rsp.count, want_rsp.count);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_rsp_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(rsp_burst) : 0;
                if (stall_left > 0) begin
                    stall_left--;
                    i_rsp_stall <= 1'b1;
                end else begin
                    i_rsp_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** bounded_list_store: FAILED **");
            $finish;
        end
    end

    initial begin
        // Empty list: every indexed operation is rejected.
        plan(OP_READ, 0, 0, rand_word());
        plan(OP_WRITE, 0, 0, '1);
        plan(OP_SWAP, 0, 0, '0);
        plan(OP_REMOVE, 0, 0, '0);
        plan(OP_APPEND, 0, 0, '1);
        plan(OP_APPEND, DEPTH - 1, DEPTH - 1, '0);
        plan(OP_APPEND, 0, 0, 64'h0123_4567_89ab_cdef);
        plan(OP_READ, 0, 0, '0);
        plan(OP_READ, 2, 0, '1);
        plan(OP_READ, 3, 0, '0);
        plan(OP_READ, DEPTH - 1, 0, '0);
        plan(OP_WRITE, 1, 0, 64'ha5a5_5a5a_c3c3_3c3c);
        plan(OP_WRITE, 3, 0, '1);
        plan(OP_SWAP, 0, 2, '0);
        plan(OP_SWAP, 1, 1, '0);
        plan(OP_SWAP, 0, 3, '0);
        plan(OP_SWAP, DEPTH - 1, 0, '0);
        plan(OP_SPARE_A, 1, 2, '1);
        plan(OP_SPARE_B, DEPTH - 1, DEPTH - 1, '0);
        plan(OP_SPARE_C, 0, 0, rand_word());
        // Remove the last word, then the first to force a shift.
        plan(OP_REMOVE, 2, 0, '0);
        plan(OP_REMOVE, 0, 0, '0);
        plan(OP_READ, 0, 0, '0);
        plan(OP_REMOVE, 1, 0, '0);

        plan_random(35, 15, 1'b1);
        repeat (299) plan_random(35, 15, 1'b0);

        // Fill to capacity, mostly appends with other traffic mixed in.
        while (plan_len < DEPTH) begin
            if ($urandom_range(0, 99) < 85) plan(OP_APPEND, 0, 0, rand_word());
            else plan_random(0, 20, 1'b0);
        end
        plan(OP_APPEND, 0, 0, rand_word(), 1'b1);
        plan(OP_APPEND, DEPTH - 1, DEPTH - 1, '1);
        plan(OP_READ, DEPTH - 1, 0, '0);
        plan(OP_WRITE, DEPTH - 1, 0, '1);
        plan(OP_SWAP, 0, DEPTH - 1, '0);
        plan(OP_SWAP, DEPTH - 1, DEPTH - 1, '0);
        plan(OP_READ, 0, 0, '0);
        plan(OP_REMOVE, DEPTH - 1, 0, '0);
        plan(OP_APPEND, 0, 0, rand_word());
        plan(OP_APPEND, 0, 0, rand_word());
        plan(OP_REMOVE, 0, 0, '0);
        plan(OP_READ, DEPTH - 2, 0, '0);

        // Shrink back down.
        plan_random(10, 45, 1'b1);
        while (req_plan_q.size() < TOTAL_TARGET) plan_random(10, 45, 1'b0);
        total_items = req_plan_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (items_sent == total_items && rsp_seen >= total_items);
        repeat (64) @(posedge i_clk);
        if (expected_rsp_q.size() != 0)
            report_mismatch("requests left unanswered", 0, expected_rsp_q.size());

        if (mismatches == 0) begin
            $display("** bounded_list_store: PASSED **");
        end else begin
            $display("** bounded_list_store: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bls_pkg.sv
rtl/bls_ram.sv
rtl/bls_out.sv
rtl/bls_seq.sv
rtl/bounded_list_store.sv
verif/tb_bounded_list_store.sv
